@@ rtl/core/sm3_block_compression_top_assert.svh @@
// assertion macros for the sm3 block compression core
`ifndef SM3_BLOCK_COMPRESSION_TOP_ASSERT_SVH
`define SM3_BLOCK_COMPRESSION_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SM3BC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SM3BC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sm3bc_pkg.sv @@
package sm3bc_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic        start_message;
    } sm3bc_in_t;

    typedef struct packed {
        logic [31:0] hash_word_0;
        logic [31:0] hash_word_1;
        logic [31:0] hash_word_2;
        logic [31:0] hash_word_3;
        logic [31:0] hash_word_4;
        logic [31:0] hash_word_5;
        logic [31:0] hash_word_6;
        logic [31:0] hash_word_7;
    } sm3bc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ROUND  = 3'b010,
        ST_FINISH = 3'b100
    } sm3bc_state_t;

    localparam int unsigned WINDOW_WORDS = 16;
    localparam int unsigned CHAIN_WORDS  = 8;

    localparam logic [3:0] LAST_WORD    = 4'd15;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [5:0] SWITCH_ROUND = 6'd15;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    // high-round constant already rotated by sixteen, its first use
    localparam logic [31:0] T_HIGH_ROT16 = 32'h9D8A7A87;

    localparam logic [31:0] SM3_IV [CHAIN_WORDS] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

@@ rtl/core/sm3_block_compression_top.sv @@
// SM3 compression core. Feed padded message data one 32-bit big-endian word per beat on
// msg; a beat with start_message set reloads the initial value and begins a new block.
// Words are taken one per cycle while msg_ready is high, into a sixteen-word sliding
// window. The sixteenth word of a block starts 64 rounds on a single round unit, one round
// per cycle, with message expansion done on the fly in the same window; then the result is
// folded into the chaining value and the eight words are placed on hash. msg_ready is low
// from the sixteenth word until that fold; the fold waits only if the previous hash beat
// has not yet been taken.
module sm3_block_compression_top
    import sm3bc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_ready,
    input  sm3bc_in_t  msg,
    output logic       hash_valid,
    input  logic       hash_ready,
    output sm3bc_out_t hash
);

`include "sm3_block_compression_top_assert.svh"

    sm3bc_state_t state_reg, state_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [5:0]   round_reg, round_next;
    logic         hash_valid_reg, hash_valid_next;
    logic [31:0]  chain_reg [CHAIN_WORDS];
    logic [31:0]  chain_next [CHAIN_WORDS];
    logic [31:0]  win_reg [WINDOW_WORDS];
    logic [31:0]  win_next [WINDOW_WORDS];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;
    logic [31:0]  tj_reg, tj_next;
    sm3bc_out_t   hash_reg, hash_next;

    logic         msg_fire;
    logic [3:0]   cnt_base;
    logic         shift_en;
    logic [31:0]  shift_word;
    logic         low_round;
    logic [31:0]  a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    logic [31:0]  fold [CHAIN_WORDS];

    assign msg_ready  = (state_reg == ST_IDLE);
    assign msg_fire   = msg_valid && msg_ready;
    assign hash_valid = hash_valid_reg;
    assign hash       = hash_reg;

    // round unit
    always_comb
    begin
        low_round = (round_reg[5:4] == 2'b00);
        a12 = rotl32(a_reg, 5'd12);
        ss1 = rotl32(a12 + e_reg + tj_reg, 5'd7);
        ss2 = ss1 ^ a12;
        if (low_round)
        begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end
        else
        begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1 = ff + d_reg + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + h_reg + ss1 + win_reg[0];
        w_new = perm1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 5'd15))
              ^ rotl32(win_reg[3], 5'd7) ^ win_reg[10];
        fold[0] = chain_reg[0] ^ a_reg;
        fold[1] = chain_reg[1] ^ b_reg;
        fold[2] = chain_reg[2] ^ c_reg;
        fold[3] = chain_reg[3] ^ d_reg;
        fold[4] = chain_reg[4] ^ e_reg;
        fold[5] = chain_reg[5] ^ f_reg;
        fold[6] = chain_reg[6] ^ g_reg;
        fold[7] = chain_reg[7] ^ h_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        round_next      = round_reg;
        hash_valid_next = hash_valid_reg;
        chain_next      = chain_reg;
        hash_next       = hash_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; f_next = f_reg; g_next = g_reg; h_next = h_reg;
        tj_next    = tj_reg;
        shift_en   = 1'b0;
        shift_word = msg.msg_word;
        cnt_base   = msg.start_message ? 4'd0 : cnt_reg;

        if (hash_valid_reg && hash_ready)
        begin
            hash_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_fire)
                begin
                    shift_en = 1'b1;
                    cnt_next = cnt_base + 4'd1;
                    if (msg.start_message)
                    begin
                        chain_next = SM3_IV;
                    end
                    if (cnt_base == LAST_WORD)
                    begin
                        state_next = ST_ROUND;
                        round_next = 6'd0;
                        tj_next    = T_LOW;
                        a_next = chain_reg[0]; b_next = chain_reg[1];
                        c_next = chain_reg[2]; d_next = chain_reg[3];
                        e_next = chain_reg[4]; f_next = chain_reg[5];
                        g_next = chain_reg[6]; h_next = chain_reg[7];
                    end
                end
            end
            ST_ROUND:
            begin
                shift_en   = 1'b1;
                shift_word = w_new;
                d_next = c_reg;
                c_next = rotl32(b_reg, 5'd9);
                b_next = a_reg;
                a_next = tt1;
                h_next = g_reg;
                g_next = rotl32(f_reg, 5'd19);
                f_next = e_reg;
                e_next = perm0(tt2);
                tj_next = (round_reg == SWITCH_ROUND) ? T_HIGH_ROT16 : rotl32(tj_reg, 5'd1);
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!hash_valid_reg || hash_ready)
                begin
                    chain_next      = fold;
                    hash_valid_next = 1'b1;
                    hash_next       = '{fold[0], fold[1], fold[2], fold[3],
                                        fold[4], fold[5], fold[6], fold[7]};
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        for (int i = 0; i < WINDOW_WORDS - 1; i++)
        begin
            win_next[i] = shift_en ? win_reg[i + 1] : win_reg[i];
        end
        win_next[WINDOW_WORDS - 1] = shift_en ? shift_word : win_reg[WINDOW_WORDS - 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= 4'd0;
            round_reg      <= 6'd0;
            hash_valid_reg <= 1'b0;
            chain_reg      <= SM3_IV;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            round_reg      <= round_next;
            hash_valid_reg <= hash_valid_next;
            chain_reg      <= chain_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        e_reg    <= e_next;
        f_reg    <= f_next;
        g_reg    <= g_next;
        h_reg    <= h_next;
        tj_reg   <= tj_next;
        hash_reg <= hash_next;
    end

    `SM3BC_ASSERT_NEXT(a_block_starts_rounds,
        msg_fire && !msg.start_message && cnt_reg == LAST_WORD,
        state_reg == ST_ROUND && round_reg == 6'd0,
        "sixteenth word did not start the rounds")
    `SM3BC_ASSERT_NEXT(a_rounds_end,
        state_reg == ST_ROUND && round_reg == LAST_ROUND,
        state_reg == ST_FINISH,
        "last round did not lead to the fold")
    `SM3BC_ASSERT_NOW(a_hash_from_fold,
        $rose(hash_valid),
        $past(state_reg == ST_FINISH),
        "hash beat raised outside the fold")
    `SM3BC_ASSERT_NEXT(a_fold_waits,
        state_reg == ST_FINISH && hash_valid && !hash_ready,
        state_reg == ST_FINISH,
        "fold overwrote an untaken hash beat")
    `SM3BC_ASSERT_NOW(a_busy_not_ready,
        state_reg != ST_IDLE,
        !msg_ready,
        "message taken while compressing")

endmodule
